// ----- src/ray_box_slab_intersect_core_macros.svh -----
// Assertion macros used by the ray/box slab intersect core.
`ifndef RAY_BOX_SLAB_INTERSECT_CORE_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define RBS_CHECK(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbs check failed");
// Consequent must hold in the cycle after the antecedent.
`define RBS_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbs check failed");
`else
`define RBS_CHECK(lbl, clk, rst_n, ante, cons)
`define RBS_CHECK_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/rbs_pkg.sv -----
package rbs_pkg;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int QW = CW + FB;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } in_t;

  typedef struct packed {
    logic   hit;
    coord_t hit_distance;
  } out_t;

  // One division: unsigned magnitudes and the sign of the quotient.
  typedef struct packed {
    logic [CW-1:0] mag;
    logic [CW-1:0] dm;
    logic          neg;
  } div_op_t;

  // Flags carried alongside the dividers: a zero-direction bit per axis and a flat-axis miss.
  typedef struct packed {
    logic [2:0] dzero;
    logic       zmiss;
  } meta_t;

endpackage

// ----- src/rbs_prep.sv -----
module rbs_prep import rbs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  in_t                item_i,
  output div_op_t [5:0]      op_o,
  output meta_t              meta_o
);

  div_op_t [5:0] op_nxt;
  meta_t         meta_nxt;
  div_op_t [5:0] op_r;
  meta_t         meta_r;
  coord_t        org [3];
  coord_t        dir [3];
  coord_t        bmin [3];
  coord_t        bmax [3];

  function automatic div_op_t make_op(coord_t b, coord_t o, coord_t d);
    logic [CW:0] diff;
    div_op_t     op;
    if (b >= o) begin
      diff   = {b[CW-1], b} - {o[CW-1], o};
      op.neg = 1'b0;
    end else begin
      diff   = {o[CW-1], o} - {b[CW-1], b};
      op.neg = 1'b1;
    end
    op.mag = diff[CW-1:0];
    op.dm  = d[CW-1] ? (~d + 1'b1) : d;
    op.neg = op.neg ^ d[CW-1];
    return op;
  endfunction

  always_comb begin
    org  = '{item_i.origin_x, item_i.origin_y, item_i.origin_z};
    dir  = '{item_i.dir_x, item_i.dir_y, item_i.dir_z};
    bmin = '{item_i.box_min_x, item_i.box_min_y, item_i.box_min_z};
    bmax = '{item_i.box_max_x, item_i.box_max_y, item_i.box_max_z};
    meta_nxt = '0;
    for (int a = 0; a < 3; a++) begin
      op_nxt[a]     = make_op(bmin[a], org[a], dir[a]);
      op_nxt[3 + a] = make_op(bmax[a], org[a], dir[a]);
      meta_nxt.dzero[a] = (dir[a] == '0);
      // A flat axis misses when the origin lies outside both bounds.
      if (meta_nxt.dzero[a] &&
          ((org[a] < bmin[a] && org[a] < bmax[a]) ||
           (org[a] > bmin[a] && org[a] > bmax[a]))) begin
        meta_nxt.zmiss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r   <= op_nxt;
      meta_r <= meta_nxt;
    end
  end

  assign op_o   = op_r;
  assign meta_o = meta_r;

endmodule

// ----- src/rbs_div_pipe.sv -----
module rbs_div_pipe import rbs_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  div_op_t       op_i,
  output logic [QW-1:0] q_o,
  output logic          neg_o
);

  // Restoring division, one quotient bit per stage. The dividend shifts
  // out of the top of n_r while quotient bits shift in at the bottom.
  logic [CW-1:0] r_r  [QW];
  logic [QW-1:0] n_r  [QW];
  logic [CW-1:0] dm_r [QW];
  logic          ng_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [CW-1:0] r_in;
    logic [QW-1:0] n_in;
    logic [CW-1:0] dm_in;
    logic          ng_in;
    logic [CW:0]   rs;
    logic [CW:0]   rd;
    logic          qb;

    if (k == 0) begin : g_first
      assign r_in  = '0;
      assign n_in  = {op_i.mag, {FB{1'b0}}};
      assign dm_in = op_i.dm;
      assign ng_in = op_i.neg;
    end else begin : g_next
      assign r_in  = r_r[k-1];
      assign n_in  = n_r[k-1];
      assign dm_in = dm_r[k-1];
      assign ng_in = ng_r[k-1];
    end

    assign rs = {r_in, n_in[QW-1]};
    assign rd = rs - {1'b0, dm_in};
    assign qb = (rs >= {1'b0, dm_in});

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]  <= qb ? rd[CW-1:0] : rs[CW-1:0];
        n_r[k]  <= {n_in[QW-2:0], qb};
        dm_r[k] <= dm_in;
        ng_r[k] <= ng_in;
      end
    end
  end

  assign q_o   = n_r[QW-1];
  assign neg_o = ng_r[QW-1] | (r_r[QW-1] == dm_r[QW-1] && 1'b0);

endmodule

// ----- src/rbs_resolve.sv -----
module rbs_resolve import rbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  logic [5:0][QW-1:0] q_i,
  input  logic [5:0]         neg_i,
  input  meta_t              meta_i,
  output logic               valid_o,
  output out_t               data_o
);

  localparam coord_t MaxPos = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t MaxNeg = {1'b1, {(CW-1){1'b0}}};

  coord_t  t [6];
  coord_t  tlo_nxt [3];
  coord_t  thi_nxt [3];
  coord_t  tlo_r [3];
  coord_t  thi_r [3];
  meta_t   meta_r;
  logic    v1_r;
  logic    vo_r;
  out_t    res_nxt;
  out_t    res_r;

  // Stage one: saturate, apply the sign and order each slab pair.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      if (|q_i[i][QW-1:CW-1]) begin
        t[i] = neg_i[i] ? MaxNeg : MaxPos;
      end else begin
        t[i] = neg_i[i] ? coord_t'(-q_i[i][CW-1:0]) : coord_t'(q_i[i][CW-1:0]);
      end
    end
    for (int a = 0; a < 3; a++) begin
      tlo_nxt[a] = (t[a] > t[3 + a]) ? t[3 + a] : t[a];
      thi_nxt[a] = (t[a] > t[3 + a]) ? t[a] : t[3 + a];
    end
  end

  // Stage two: narrow the interval axis by axis and decide.
  always_comb begin
    logic   bounded;
    logic   miss;
    coord_t lo;
    coord_t hi;
    bounded = 1'b0;
    miss    = meta_r.zmiss;
    lo      = '0;
    hi      = '0;
    for (int a = 0; a < 3; a++) begin
      if (!meta_r.dzero[a]) begin
        if (!bounded) begin
          lo = tlo_r[a];
          hi = thi_r[a];
          bounded = 1'b1;
        end else begin
          if (lo > thi_r[a] || tlo_r[a] > hi) miss = 1'b1;
          if (tlo_r[a] > lo) lo = tlo_r[a];
          if (thi_r[a] < hi) hi = thi_r[a];
        end
      end
    end
    if (bounded && hi[CW-1]) miss = 1'b1;
    res_nxt = '0;
    if (!miss) begin
      res_nxt.hit = 1'b1;
      if (!bounded) res_nxt.hit_distance = MaxPos;
      else res_nxt.hit_distance = lo[CW-1] ? hi : lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      vo_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tlo_r  <= tlo_nxt;
      thi_r  <= thi_nxt;
      meta_r <= meta_i;
      res_r  <= res_nxt;
    end
  end

  assign valid_o = vo_r;
  assign data_o  = res_r;

endmodule

// ----- src/ray_box_slab_intersect_core.sv -----
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid, in_stall  | in_data  (in_t, ray and box)
// out_    | output    | out_valid, out_stall| out_data (out_t, hit and distance)
//
// One transaction is accepted every cycle unless in_stall is high; its valid
// passes the prep, bit-per-stage divider and resolve registers. Distance is Q16.16.
// Reset (rst_n low, synchronous) clears only the valid bits of the pipeline.
// A stalled result freezes the whole pipeline; in_stall follows at once, so
// nothing is lost or repeated.
`include "ray_box_slab_intersect_core_macros.svh"

module ray_box_slab_intersect_core import rbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // The pipeline advances as one whenever the output register can move.
  logic               adv;
  div_op_t [5:0]      op;
  meta_t              meta0;
  logic               pv_r;
  logic [QW-1:0]      dv_r;
  meta_t              meta_r [QW];
  logic [5:0][QW-1:0] q;
  logic [5:0]         neg;

  assign in_stall = out_valid & out_stall;
  assign adv      = ~in_stall;

  rbs_prep u_prep (
    .clk    (clk),
    .en     (adv),
    .item_i (in_data),
    .op_o   (op),
    .meta_o (meta0)
  );

  // Six dividers: index a is the lower bound of axis a, 3+a the upper.
  for (genvar i = 0; i < 6; i++) begin : g_div
    rbs_div_pipe u_div (
      .clk   (clk),
      .en    (adv),
      .op_i  (op[i]),
      .q_o   (q[i]),
      .neg_o (neg[i])
    );
  end

  // Valid bits and flat-axis flags travel beside the division stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      dv_r <= '0;
    end else if (adv) begin
      pv_r <= in_valid;
      dv_r <= {dv_r[QW-2:0], pv_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= meta0;
      for (int k = 1; k < QW; k++) meta_r[k] <= meta_r[k-1];
    end
  end

  rbs_resolve u_resolve (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .valid_i (dv_r[QW-1]),
    .q_i     (q),
    .neg_i   (neg),
    .meta_i  (meta_r[QW-1]),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

  `RBS_CHECK(a_miss_zero, clk, rst_n, out_valid && !out_data.hit, out_data.hit_distance == '0)
  `RBS_CHECK(a_hit_ahead, clk, rst_n, out_valid && out_data.hit, !out_data.hit_distance[CW-1])
  `RBS_CHECK_NEXT(a_freeze, clk, rst_n, in_stall, $stable(dv_r) && $stable(pv_r))
  `RBS_CHECK_NEXT(a_accept, clk, rst_n, in_valid && !in_stall, pv_r)

endmodule
